FILE: hdl/sktl_pkg.sv
`timescale 1ns / 1ps

package sktl_pkg;

  localparam int KEY_W         = 32;
  localparam int DATA_W        = 32;
  localparam int STATUS_W      = 3;
  localparam int SLOT_W        = 8;
  localparam int DEFAULT_DEPTH = 256;

  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] payload;
  } entry_t;

endpackage

FILE: hdl/sorted_key_table_lookup_insert.sv
`timescale 1ns / 1ps
// a lookup or update runs a binary search over the n stored entries, each probe passing
// through ST_SEARCH and ST_CMP around the registered memory read
// an insert then moves each larger entry up one place before writing the new one
// one request at a time: busy is high from the accepting edge until the result strobe
// synchronous reset empties the table (entry count zero) and returns to idle
// the result is shown for one cycle on done; the receiver cannot stall
module sorted_key_table_lookup_insert #(
  parameter int TABLE_DEPTH = sktl_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [sktl_pkg::KEY_W-1:0]    key,
  input  logic [sktl_pkg::DATA_W-1:0]   entry_data,
  output logic                          done,
  output logic [sktl_pkg::STATUS_W-1:0] status,
  output logic [sktl_pkg::SLOT_W-1:0]   slot,
  output logic [sktl_pkg::DATA_W-1:0]   payload
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = CNT_W + sktl_pkg::SLOT_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_CMP    = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_SHIFT  = 6'b010000,
    ST_INSERT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]                 entry_count;
  logic [CNT_W-1:0]                 lo;
  logic [CNT_W-1:0]                 hi;
  logic [CNT_W-1:0]                 sh;
  logic                             req_q;
  logic [sktl_pkg::KEY_W-1:0]       key_q;
  logic [sktl_pkg::DATA_W-1:0]      data_q;

  logic [CNT_W-1:0]                 mid;
  logic [CNT_W-1:0]                 sh_dec;
  logic                             hit;
  logic                             full;
  logic                             finish;
  logic [sktl_pkg::STATUS_W-1:0]    res_status;
  logic [sktl_pkg::DATA_W-1:0]      res_payload;
  logic [EXT_W-1:0]                 lo_ext;

  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_waddr;
  logic [IDX_W-1:0]                 mem_raddr;
  sktl_pkg::entry_t                 mem_wdata;
  sktl_pkg::entry_t                 mem_rdata;

  sktl_store #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign mid    = lo + ((hi - lo) >> 1);
  assign sh_dec = sh - CNT_W'(1);
  assign hit    = (lo < entry_count) && (mem_rdata.key == key_q);
  assign full   = (entry_count == CNT_W'(TABLE_DEPTH));
  assign lo_ext = {{sktl_pkg::SLOT_W{1'b0}}, lo};

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lo[IDX_W-1:0];
    mem_wdata = '{key: key_q, payload: data_q};
    mem_raddr = mid[IDX_W-1:0];
    unique case (state)
      ST_SEARCH: begin
        // probe the midpoint, or the insertion point once the range is empty
        mem_raddr = (lo < hi) ? mid[IDX_W-1:0] : lo[IDX_W-1:0];
      end
      ST_CHECK: begin
        // prefetch the top entry for a shift
        mem_raddr = entry_count[IDX_W-1:0] - IDX_W'(1);
        mem_we    = (req_q == sktl_pkg::REQ_WRITE) && hit;
      end
      ST_SHIFT: begin
        // write the entry read last cycle one place up, prefetch the next one down
        mem_we    = 1'b1;
        mem_waddr = sh[IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = sh_dec[IDX_W-1:0] - IDX_W'(1);
      end
      ST_INSERT: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state and result selection
  always_comb begin
    state_next  = state;
    finish      = 1'b0;
    res_status  = sktl_pkg::STAT_NOT_FOUND;
    res_payload = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_next = (lo < hi) ? ST_CMP : ST_CHECK;
      end
      ST_CMP: begin
        state_next = ST_SEARCH;
      end
      ST_CHECK: begin
        if (req_q == sktl_pkg::REQ_LOOKUP) begin
          finish      = 1'b1;
          res_status  = hit ? sktl_pkg::STAT_FOUND : sktl_pkg::STAT_NOT_FOUND;
          res_payload = hit ? mem_rdata.payload : '0;
          state_next  = ST_IDLE;
        end else if (hit) begin
          finish      = 1'b1;
          res_status  = sktl_pkg::STAT_UPDATED;
          res_payload = data_q;
          state_next  = ST_IDLE;
        end else if (full) begin
          finish      = 1'b1;
          res_status  = sktl_pkg::STAT_FULL;
          state_next  = ST_IDLE;
        end else begin
          state_next = (entry_count > lo) ? ST_SHIFT : ST_INSERT;
        end
      end
      ST_SHIFT: begin
        if (!(sh_dec > lo)) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        finish      = 1'b1;
        res_status  = sktl_pkg::STAT_INSERTED;
        res_payload = data_q;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      entry_count <= '0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (state == ST_INSERT) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req_q  <= req_type;
        key_q  <= key;
        data_q <= entry_data;
        lo     <= '0;
        hi     <= entry_count;
      end
      ST_CMP: begin
        if (mem_rdata.key < key_q) begin
          lo <= mid + CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
      ST_CHECK: begin
        sh <= entry_count;
      end
      ST_SHIFT: begin
        sh <= sh_dec;
      end
      default: begin
      end
    endcase
    if (finish) begin
      status  <= res_status;
      payload <= res_payload;
      slot    <= (res_status == sktl_pkg::STAT_NOT_FOUND || res_status == sktl_pkg::STAT_FULL)
                 ? '0 : lo_ext[sktl_pkg::SLOT_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != ST_IDLE)
    else $error("result strobe without a request in progress");

  a_count_on_insert: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && entry_count != $past(entry_count)
      |-> done && status == sktl_pkg::STAT_INSERTED)
    else $error("entry count changed without an insert result");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    done && status == sktl_pkg::STAT_FULL |-> entry_count == CNT_W'(TABLE_DEPTH))
    else $error("table full reported while space remains");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request transfer did not raise busy");
`endif

endmodule

FILE: hdl/sktl_store.sv
`timescale 1ns / 1ps

module sktl_store #(
  parameter int DEPTH = sktl_pkg::DEFAULT_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  sktl_pkg::entry_t     wdata,
  input  logic [IDX_W-1:0]     raddr,
  output sktl_pkg::entry_t     rdata
);

  sktl_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = sktl_pkg::DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int GROW_ITEMS = 650;
  localparam int FULL_ITEMS = 630;

  typedef struct packed {
    logic [sktl_pkg::STATUS_W-1:0] status;
    logic [sktl_pkg::SLOT_W-1:0]   slot;
    logic [sktl_pkg::DATA_W-1:0]   payload;
  } answer_t;

  class table_scoreboard;
    logic [sktl_pkg::KEY_W-1:0]  keys [DEPTH];
    logic [sktl_pkg::DATA_W-1:0] words [DEPTH];
    int unsigned                 count;
    answer_t                     pending_answers [$];
    int                          errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    // number of stored keys below k
    function int unsigned insertion_point(logic [sktl_pkg::KEY_W-1:0] k);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_request(logic r, logic [sktl_pkg::KEY_W-1:0] k,
                               logic [sktl_pkg::DATA_W-1:0] d);
      int unsigned pos;
      int unsigned i;
      bit          hit;
      answer_t     a;
      pos = insertion_point(k);
      hit = (pos < count) && (keys[pos] == k);
      a.status = sktl_pkg::STAT_NOT_FOUND;
      a.slot = '0;
      a.payload = '0;
      if (r == sktl_pkg::REQ_LOOKUP) begin
        if (hit) begin
          a.status = sktl_pkg::STAT_FOUND;
          a.slot = pos[sktl_pkg::SLOT_W-1:0];
          a.payload = words[pos];
        end
      end else if (hit) begin
        words[pos] = d;
        a.status = sktl_pkg::STAT_UPDATED;
        a.slot = pos[sktl_pkg::SLOT_W-1:0];
        a.payload = d;
      end else if (count >= DEPTH) begin
        a.status = sktl_pkg::STAT_FULL;
      end else begin
        // open a gap at pos by moving the larger keys up
        for (i = count; i > pos; i--) begin
          keys[i] = keys[i-1];
          words[i] = words[i-1];
        end
        keys[pos] = k;
        words[pos] = d;
        count++;
        a.status = sktl_pkg::STAT_INSERTED;
        a.slot = pos[sktl_pkg::SLOT_W-1:0];
        a.payload = d;
      end
      pending_answers.push_back(a);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 200) $display("mismatch: %s", msg);
    endtask

    task check_answer(logic [sktl_pkg::STATUS_W-1:0] st, logic [sktl_pkg::SLOT_W-1:0] sl,
                      logic [sktl_pkg::DATA_W-1:0] pl);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d slot %0d payload %h",
                                  st, sl, pl));
        return;
      end
      want = pending_answers.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
      if (sl !== want.slot)
        report_mismatch($sformatf("slot %0d, expected %0d", sl, want.slot));
      if (pl !== want.payload)
        report_mismatch($sformatf("payload %h, expected %h", pl, want.payload));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          req_type = sktl_pkg::REQ_LOOKUP;
  logic [sktl_pkg::KEY_W-1:0]    key = '0;
  logic [sktl_pkg::DATA_W-1:0]   entry_data = '0;
  logic                          busy;
  logic                          done;
  logic [sktl_pkg::STATUS_W-1:0] status;
  logic [sktl_pkg::SLOT_W-1:0]   slot;
  logic [sktl_pkg::DATA_W-1:0]   payload;

  table_scoreboard sb = new();
  int unsigned     cycles = 0;
  int              quiet_left = 0;

  sorted_key_table_lookup_insert #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .key(key),
    .entry_data(entry_data),
    .done(done),
    .status(status),
    .slot(slot),
    .payload(payload)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_answer(status, slot, payload);
  end

  // start stays high across back-to-back transfers
  task send(logic r, logic [sktl_pkg::KEY_W-1:0] k, logic [sktl_pkg::DATA_W-1:0] d);
    int gap;
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(10, 40);
      gap = $urandom_range(0, 19);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= r;
    key <= k;
    entry_data <= d;
    do @(posedge clk); while (busy);
    sb.note_request(r, k, d);
  endtask

  task wait_drained();
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  function logic [sktl_pkg::KEY_W-1:0] stored_key();
    return sb.keys[$urandom_range(0, sb.count - 1)];
  endfunction

  // random key, or one just beside a stored key to probe search boundaries
  function logic [sktl_pkg::KEY_W-1:0] probe_key();
    logic [sktl_pkg::KEY_W-1:0] k;
    if (sb.count == 0 || $urandom_range(0, 9) < 7) return $urandom;
    k = stored_key();
    return $urandom_range(0, 1) ? k + 1 : k - 1;
  endfunction

  task random_request();
    int p;
    p = $urandom_range(0, 99);
    if (sb.count == 0 || p >= 75) send(sktl_pkg::REQ_WRITE, probe_key(), $urandom);
    else if (p < 25) send(sktl_pkg::REQ_LOOKUP, stored_key(), $urandom);
    else if (p < 45) send(sktl_pkg::REQ_LOOKUP, probe_key(), $urandom);
    else send(sktl_pkg::REQ_WRITE, stored_key(), $urandom);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, key and payload extremes, update, shifting inserts
    send(sktl_pkg::REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send(sktl_pkg::REQ_WRITE, 32'h8000_0000, 32'hFFFF_FFFF);
    send(sktl_pkg::REQ_WRITE, 32'h0000_0000, 32'h0000_0000);
    send(sktl_pkg::REQ_WRITE, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send(sktl_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send(sktl_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send(sktl_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    send(sktl_pkg::REQ_WRITE, 32'h8000_0000, 32'h0000_0000);
    send(sktl_pkg::REQ_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
    send(sktl_pkg::REQ_WRITE, 32'h8000_0001, 32'h5A5A_5A5A);
    send(sktl_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
    send(sktl_pkg::REQ_WRITE, 32'h0000_0001, 32'h1234_5678);
    send(sktl_pkg::REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    send(sktl_pkg::REQ_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(sktl_pkg::REQ_LOOKUP, 32'h8000_0001, 32'h0000_0000);

    // mixed traffic while the table grows
    repeat (GROW_ITEMS) random_request();

    // sender holds off until every result is back
    start <= 1'b0;
    wait_drained();

    while (sb.count < DEPTH) send(sktl_pkg::REQ_WRITE, probe_key(), $urandom);

    // full table: new keys are refused, updates still land
    repeat (FULL_ITEMS) random_request();

    start <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
